/* design/bba_pkg.sv */
// shared types and constants of the bitmap block allocator
package bba_pkg;

	// default sizes of the use map
	localparam int NUM_BLOCKS_DEF    = 4096;
	localparam int MAP_WORD_BITS_DEF = 32;

	// fixed field widths
	localparam int TOTAL_W = 13;
	localparam int BLK_W   = 12;

	// reset value of the total register
	localparam logic [TOTAL_W-1:0] TOTAL_RST = 13'd4096;

	// request codes
	typedef enum logic {
		REQ_ALLOC = 1'b0,
		REQ_FREE  = 1'b1
	} req_type_t;

	// result codes
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_BADFREE = 2'd2
	} status_t;

	// request beat
	typedef struct packed {
		req_type_t        req_type;
		logic [BLK_W-1:0] block_num;
	} req_t;

	// result beat
	typedef struct packed {
		status_t          status;
		logic [BLK_W-1:0] block_num_out;
	} rsp_t;

	// sequencer states
	typedef enum logic [2:0] {
		S_CLR,
		S_IDLE,
		S_ALLOC,
		S_FRD,
		S_FEVAL,
		S_RESP
	} state_t;

endpackage

/* design/block_bitmap_allocator.sv */
// first-fit bitmap block allocator: sequencer, scan pipeline and use-map ram
//
// Request beats come in on in_valid/in_ready/in_data, one result beat per
// request leaves on out_valid/out_ready/out_data. cfg_we/cfg_data write the
// total number of allocatable blocks; write it only while no request is open.
// Allocate scans the use map one word per cycle through the ram read port and
// stops at the first word holding a free bit below the total, or at the last
// word below the total when no block is free. Free splits the block number
// into word and bit by a reciprocal multiply, then reads one word and writes
// it back with the bit cleared if the block was in use. An out-of-range free
// or an allocate with a zero total answers without touching the map. One
// request is handled at a time, and the sequencer returns to idle before it
// takes the next.
// A new request is taken while the last result still sits in the output
// register; its result waits until the receiver takes the old one, so a
// stalled receiver holds the block with one result in the output register
// and one more waiting.
// After reset the map is cleared one word per cycle, all MAP_WORDS words (128
// by default), with in_ready low; configuration writes are taken throughout.
module block_bitmap_allocator #(
	parameter int NUM_BLOCKS    = bba_pkg::NUM_BLOCKS_DEF,
	parameter int MAP_WORD_BITS = bba_pkg::MAP_WORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [bba_pkg::TOTAL_W-1:0]  cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  bba_pkg::req_t                in_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output bba_pkg::rsp_t                out_data
);

	localparam int MAP_WORDS = (NUM_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
	localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int BIT_W     = $clog2(MAP_WORD_BITS);
	localparam int CW_A      = $clog2(NUM_BLOCKS + 2 * MAP_WORD_BITS) + 1;
	localparam int CW        = (CW_A > bba_pkg::TOTAL_W) ? CW_A : bba_pkg::TOTAL_W;
	localparam int BLK_W     = bba_pkg::BLK_W;
	localparam int RCP_SH    = BLK_W + BIT_W;
	localparam int RCP_W     = BLK_W + 1;
	localparam int PRD_W     = BLK_W + RCP_W;

	localparam logic [AW-1:0]            LAST_WORD = AW'(MAP_WORDS - 1);
	localparam logic [CW-1:0]            CAP       = CW'(NUM_BLOCKS);
	localparam logic [CW-1:0]            WBITS     = CW'(MAP_WORD_BITS);
	localparam logic [MAP_WORD_BITS-1:0] ONE_BIT   = MAP_WORD_BITS'(1);
	localparam logic [RCP_W-1:0]         RCP       =
		RCP_W'(((1 << RCP_SH) + MAP_WORD_BITS - 1) / MAP_WORD_BITS);

	bba_pkg::state_t state_q, state_d;

	logic [bba_pkg::TOTAL_W-1:0] total_q;
	logic [CW-1:0]               eff_total;

	logic                     ram_we, ram_re;
	logic [AW-1:0]            ram_waddr, ram_raddr;
	logic [MAP_WORD_BITS-1:0] ram_wdata, ram_rdata;

	logic [AW-1:0] clr_q;

	// scan issue side and read pipeline stage
	logic [AW-1:0] scan_q;
	logic [CW-1:0] issue_base_q, next_base;
	logic          issue_more_q;
	logic          vld_s1;
	logic [AW-1:0] addr_s1;
	logic [CW-1:0] base_s1;

	// scan evaluation
	logic [CW-1:0]            lim;
	logic [MAP_WORD_BITS-1:0] free_vec;
	logic                     found;
	logic [BIT_W-1:0]         found_idx;
	logic                     last_s1;

	// word index and bit position of a free request
	logic [PRD_W-1:0] rcp_prod;
	logic [BLK_W-1:0] blk_quo, blk_rem;
	logic [BLK_W-1:0] quo_q;
	logic [BIT_W-1:0] rem_q;

	bba_pkg::req_type_t req_q;
	bba_pkg::rsp_t      res_q, out_q;
	logic               out_valid_q;
	logic               load_out;

	// total register, clamped to the map size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= bba_pkg::TOTAL_RST;
		end else if (cfg_we) begin
			total_q <= cfg_data;
		end
	end

	assign eff_total = (CW'(total_q) > CAP) ? CAP : CW'(total_q);

	// use map
	bba_ram #(
		.WIDTH (MAP_WORD_BITS),
		.DEPTH (MAP_WORDS)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// lowest free bit of the word in flight, limited to the total
	always_comb begin
		lim       = eff_total - base_s1;
		found     = 1'b0;
		found_idx = '0;
		for (int b = 0; b < MAP_WORD_BITS; b++) begin
			free_vec[b] = !ram_rdata[b] && (CW'(b) < lim);
		end
		for (int b = MAP_WORD_BITS - 1; b >= 0; b--) begin
			if (free_vec[b]) begin
				found     = 1'b1;
				found_idx = BIT_W'(b);
			end
		end
		last_s1 = (base_s1 + WBITS) >= eff_total;
	end

	assign next_base = issue_base_q + WBITS;

	// split the request block number by reciprocal multiply
	assign rcp_prod = PRD_W'(in_data.block_num) * PRD_W'(RCP);
	assign blk_quo  = BLK_W'(rcp_prod >> RCP_SH);
	assign blk_rem  = in_data.block_num - blk_quo * BLK_W'(MAP_WORD_BITS);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bba_pkg::S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and ram controls
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		load_out  = 1'b0;
		unique case (state_q)
			bba_pkg::S_CLR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				if (clr_q == LAST_WORD) begin
					state_d = bba_pkg::S_IDLE;
				end
			end
			bba_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_data.req_type == bba_pkg::REQ_ALLOC) begin
						state_d = (eff_total == '0) ? bba_pkg::S_RESP : bba_pkg::S_ALLOC;
					end else begin
						state_d = (CW'(in_data.block_num) >= eff_total) ?
							bba_pkg::S_RESP : bba_pkg::S_FRD;
					end
				end
			end
			bba_pkg::S_ALLOC: begin
				ram_re    = issue_more_q;
				ram_raddr = scan_q;
				if (vld_s1 && found) begin
					ram_we    = 1'b1;
					ram_waddr = addr_s1;
					ram_wdata = ram_rdata | (ONE_BIT << found_idx);
					state_d   = bba_pkg::S_RESP;
				end else if (vld_s1 && last_s1) begin
					state_d = bba_pkg::S_RESP;
				end
			end
			bba_pkg::S_FRD: begin
				ram_re    = 1'b1;
				ram_raddr = AW'(quo_q);
				state_d   = bba_pkg::S_FEVAL;
			end
			bba_pkg::S_FEVAL: begin
				if (ram_rdata[rem_q]) begin
					ram_we    = 1'b1;
					ram_waddr = AW'(quo_q);
					ram_wdata = ram_rdata & ~(ONE_BIT << rem_q);
				end
				state_d = bba_pkg::S_RESP;
			end
			bba_pkg::S_RESP: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = bba_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = bba_pkg::S_IDLE;
			end
		endcase
	end

	// control registers of the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q        <= '0;
			issue_more_q <= 1'b0;
			vld_s1       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (state_q == bba_pkg::S_CLR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (state_q == bba_pkg::S_IDLE && in_valid) begin
				issue_more_q <= 1'b1;
				vld_s1       <= 1'b0;
			end
			if (state_q == bba_pkg::S_ALLOC) begin
				if (vld_s1 && (found || last_s1)) begin
					issue_more_q <= 1'b0;
					vld_s1       <= 1'b0;
				end else begin
					vld_s1 <= issue_more_q;
					if (issue_more_q) begin
						issue_more_q <= next_base < eff_total;
					end
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			bba_pkg::S_IDLE: begin
				if (in_valid) begin
					req_q        <= in_data.req_type;
					scan_q       <= '0;
					issue_base_q <= '0;
					quo_q        <= blk_quo;
					rem_q        <= BIT_W'(blk_rem);
					res_q.block_num_out <= '0;
					res_q.status <= (in_data.req_type == bba_pkg::REQ_ALLOC) ?
						bba_pkg::ST_FULL : bba_pkg::ST_BADFREE;
				end
			end
			bba_pkg::S_ALLOC: begin
				if (issue_more_q) begin
					addr_s1      <= scan_q;
					base_s1      <= issue_base_q;
					scan_q       <= scan_q + AW'(1);
					issue_base_q <= next_base;
				end
				if (vld_s1 && found) begin
					res_q.status        <= bba_pkg::ST_OK;
					res_q.block_num_out <= BLK_W'(base_s1 + CW'(found_idx));
				end
			end
			bba_pkg::S_FEVAL: begin
				res_q.status <= ram_rdata[rem_q] ? bba_pkg::ST_OK : bba_pkg::ST_BADFREE;
			end
			bba_pkg::S_RESP: begin
				if (load_out) begin
					out_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// scan pipeline holds a word only while scanning
	a_s1_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> state_q == bba_pkg::S_ALLOC)
		else $error("scan stage valid outside allocate");

	// a found block lies below the effective total
	a_found_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bba_pkg::S_ALLOC && vld_s1 && found) |->
		(base_s1 + CW'(found_idx)) < eff_total)
		else $error("allocated block beyond total");

	// a map write during the scan ends it
	a_write_ends_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bba_pkg::S_ALLOC && ram_we) |=> state_q == bba_pkg::S_RESP)
		else $error("scan continued after map update");

	// free requests never report out of blocks
	a_free_status: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bba_pkg::S_RESP && req_q == bba_pkg::REQ_FREE) |->
		res_q.status != bba_pkg::ST_FULL)
		else $error("free reported out of blocks");

	// result number is zero unless ok
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.status != bba_pkg::ST_OK) |-> out_q.block_num_out == '0)
		else $error("failed request carries a block number");

endmodule

/* design/bba_ram.sv */
// generic single-write, single-read ram with registered read data
module bba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* sim/block_bitmap_allocator_chk.sv */
`timescale 1ns / 1ps
// use-map predictor and result scoreboard for the bitmap block allocator
module block_bitmap_allocator_chk (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [bba_pkg::TOTAL_W-1:0] cfg_data,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  bba_pkg::req_t               in_data,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  bba_pkg::rsp_t               out_data,
	output int                          fail_count,
	output int                          pending
);

	// shadow copy of the use map and the total register
	logic [bba_pkg::NUM_BLOCKS_DEF-1:0] used_map;
	logic [bba_pkg::TOTAL_W-1:0]        alloc_total;
	bba_pkg::rsp_t                      grant_q[$];

	// first-fit allocate or checked free against the shadow map
	function automatic bba_pkg::rsp_t grant_for(bba_pkg::req_t r);
		bba_pkg::rsp_t res;
		int            eff;
		res.status        = bba_pkg::ST_FULL;
		res.block_num_out = '0;
		eff = (int'(alloc_total) > bba_pkg::NUM_BLOCKS_DEF) ?
			bba_pkg::NUM_BLOCKS_DEF : int'(alloc_total);
		if (r.req_type == bba_pkg::REQ_ALLOC) begin
			for (int i = 0; i < eff; i++) begin
				if (!used_map[i]) begin
					used_map[i]       = 1'b1;
					res.status        = bba_pkg::ST_OK;
					res.block_num_out = bba_pkg::BLK_W'(i);
					break;
				end
			end
		end else if (int'(r.block_num) >= eff || !used_map[r.block_num]) begin
			res.status = bba_pkg::ST_BADFREE;
		end else begin
			used_map[r.block_num] = 1'b0;
			res.status            = bba_pkg::ST_OK;
		end
		return res;
	endfunction

	// track config, predict on request beats, compare on result beats
	always @(posedge clk or negedge arst_n) begin
		bba_pkg::rsp_t want;
		if (!arst_n) begin
			used_map    = '0;
			alloc_total = bba_pkg::TOTAL_RST;
			grant_q.delete();
			pending     = 0;
			fail_count  = 0;
		end else begin
			if (cfg_we)
				alloc_total = cfg_data;
			if (out_valid && out_ready) begin
				if (grant_q.size() == 0) begin
					fail_count++;
					$display("%0t: result beat expected none actual status %0d block %0d",
						$time, out_data.status, out_data.block_num_out);
				end else begin
					want = grant_q.pop_front();
					if (out_data.status !== want.status) begin
						fail_count++;
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, out_data.status);
					end
					if (out_data.block_num_out !== want.block_num_out) begin
						fail_count++;
						$display("%0t: block_num_out expected %0d actual %0d",
							$time, want.block_num_out, out_data.block_num_out);
					end
				end
			end
			if (in_valid && in_ready)
				grant_q.push_back(grant_for(in_data));
			pending = grant_q.size();
		end
	end

endmodule

/* sim/block_bitmap_allocator_tb.sv */
`timescale 1ns / 1ps
// stimulus, idling and verdict for the bitmap block allocator
module block_bitmap_allocator_tb;

	localparam int STALL_LIMIT = 2000;

	logic                        clk       = 1'b0;
	logic                        arst_n    = 1'b0;
	logic                        cfg_we    = 1'b0;
	logic [bba_pkg::TOTAL_W-1:0] cfg_data  = '0;
	logic                        in_valid  = 1'b0;
	logic                        in_ready;
	bba_pkg::req_t               in_data   = '0;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	bba_pkg::rsp_t               out_data;

	int fail_count;
	int pending;
	int idle_cycles = 0;
	bit calm        = 1'b0;

	block_bitmap_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	block_bitmap_allocator_chk chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #2 clk = ~clk;

	// watchdog: cycles without any accepted beat
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles >= STALL_LIMIT);
		$display("[block_bitmap_allocator] ERROR");
		$finish;
	end

	// receiver: random stall before each result beat
	initial begin
		int unsigned hold;
		@(posedge arst_n);
		forever begin
			hold = calm ? 0 : $urandom_range(0, 14);
			repeat (hold) begin
				@(negedge clk);
				out_ready <= 1'b0;
			end
			@(negedge clk);
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	// one request beat after a random gap, returns right after acceptance
	task automatic send_req(bba_pkg::req_type_t t, logic [bba_pkg::BLK_W-1:0] b);
		int unsigned   gap;
		bba_pkg::req_t r;
		r.req_type  = t;
		r.block_num = b;
		gap = calm ? 0 : $urandom_range(0, 14);
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_data  <= r;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	// stop sending and wait until every result beat is back
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	// write the total register while nothing is in flight
	task automatic set_total(logic [bba_pkg::TOTAL_W-1:0] v);
		drain();
		cfg_data <= v;
		cfg_we   <= 1'b1;
		@(negedge clk);
		cfg_we   <= 1'b0;
	endtask

	// random traffic under one total setting
	task automatic run_phase(logic [bba_pkg::TOTAL_W-1:0] tot, int n, int alloc_pct,
		bit pause_mid);
		int                 eff;
		int                 span;
		bba_pkg::req_type_t t;
		set_total(tot);
		calm = ($urandom_range(0, 3) == 0);
		eff  = (int'(tot) > bba_pkg::NUM_BLOCKS_DEF) ? bba_pkg::NUM_BLOCKS_DEF : int'(tot);
		span = ((eff < 200) ? eff : 200) + 3;
		for (int k = 0; k < n; k++) begin
			if (pause_mid && k == n / 2)
				drain();
			t = ($urandom_range(0, 99) < alloc_pct) ? bba_pkg::REQ_ALLOC : bba_pkg::REQ_FREE;
			if ($urandom_range(0, 3) == 0)
				send_req(t, bba_pkg::BLK_W'($urandom_range(0, 4095)));
			else
				send_req(t, bba_pkg::BLK_W'($urandom_range(0, span)));
		end
	endtask

	// reset, directed cases, random phases, verdict
	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// total above capacity acts as the full map
		set_total(13'h1FFF);
		send_req(bba_pkg::REQ_FREE, 12'd0);
		send_req(bba_pkg::REQ_FREE, 12'd4095);
		send_req(bba_pkg::REQ_ALLOC, 12'd0);
		send_req(bba_pkg::REQ_ALLOC, 12'd0);
		send_req(bba_pkg::REQ_ALLOC, 12'd4095);
		send_req(bba_pkg::REQ_FREE, 12'd1);
		send_req(bba_pkg::REQ_FREE, 12'd1);
		send_req(bba_pkg::REQ_ALLOC, 12'd2730);
		send_req(bba_pkg::REQ_FREE, 12'd4095);

		// zero total: no allocation, every free out of range
		set_total(13'd0);
		send_req(bba_pkg::REQ_ALLOC, 12'd0);
		send_req(bba_pkg::REQ_FREE, 12'd0);

		// tiny total filled up
		set_total(13'd3);
		send_req(bba_pkg::REQ_ALLOC, 12'd0);
		send_req(bba_pkg::REQ_FREE, 12'd2);
		send_req(bba_pkg::REQ_ALLOC, 12'd1365);
		send_req(bba_pkg::REQ_ALLOC, 12'd0);

		// lowered total hides a used block
		set_total(13'd2);
		send_req(bba_pkg::REQ_FREE, 12'd2);
		send_req(bba_pkg::REQ_ALLOC, 12'd0);
		send_req(bba_pkg::REQ_FREE, 12'd0);
		send_req(bba_pkg::REQ_ALLOC, 12'd0);

		// total raised again
		set_total(13'd4096);
		send_req(bba_pkg::REQ_FREE, 12'd2);
		send_req(bba_pkg::REQ_FREE, 12'd4095);
		send_req(bba_pkg::REQ_ALLOC, 12'd0);

		run_phase(13'd4096, 200, 80, 1'b0);
		run_phase(13'd40, 130, 60, 1'b0);
		run_phase(13'd0, 60, 50, 1'b0);
		run_phase(13'h1FFF, 120, 50, 1'b1);
		run_phase(13'd1, 60, 55, 1'b0);
		run_phase(bba_pkg::TOTAL_W'($urandom_range(2, 100)), 130, 60, 1'b0);
		run_phase(bba_pkg::TOTAL_W'($urandom), 100, 55, 1'b0);
		run_phase(13'd4096, 100, 50, 1'b0);

		drain();
		repeat (300) @(negedge clk);
		if (fail_count == 0)
			$display("[block_bitmap_allocator] OK");
		else
			$display("[block_bitmap_allocator] ERROR");
		$finish;
	end

endmodule
